// ===== src/pva_pkg.sv =====
`timescale 1ns / 1ps

package pva_pkg;

    // built sizes and distance scaling defaults
    localparam int NUM_VOICES_DEF     = 8;
    localparam int MAX_DIST_DEF       = 2025;
    localparam int PRIORITY_STEPS_DEF = 10;

    // request codes
    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_STOP_OWN = 3'd1;
    localparam logic [2:0] REQ_RELINK   = 3'd2;
    localparam logic [2:0] REQ_STOP_ALL = 3'd3;
    localparam logic [2:0] REQ_FINISH   = 3'd4;

    // result actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_ENABLE   = 2'd1;

    // state of one voice
    typedef struct packed {
        logic [7:0]  owner;
        logic [7:0]  sound;
        logic [11:0] prio;
        logic        playing;
    } t_voice;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_DIST,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_LIMIT,
        ST_EVICT,
        ST_OWNER,
        ST_FREE,
        ST_PLACE,
        ST_OP,
        ST_DONE,
        ST_FLUSH
    } t_state;

endpackage

// ===== src/pva_cell.sv =====
`timescale 1ns / 1ps

module pva_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  pva_pkg::t_voice i_d,
    output pva_pkg::t_voice o_q
);

    pva_pkg::t_voice r_v;

    // one voice slot, moves one place toward the head per shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_shift) begin
            r_v <= i_d;
        end
    end

    assign o_q = r_v;

endmodule

// ===== src/priority_voice_allocator.sv =====
`timescale 1ns / 1ps
// channel   | ports                                          | handshake
// request   | start, busy, i_req_type .. i_voice_index       | start & !busy
// result    | o_valid, o_action .. o_last                    | o_valid, one cycle
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | valid & ready
//
// voices sit in a ring of cells; a scan rotates the ring by NUM_VOICES places so
// each voice passes the head once. a start first works out distance and scaling
// (ABS, DIST, CHECK, then DIV with at most PRIORITY_STEPS division steps and MUL),
// then runs up to five scans and the closing DONE and FLUSH states. other requests
// take one scan and FLUSH, unknown codes only FLUSH. o_last shows in the same cycle
// that busy drops. reset is synchronous and frees all voices. results cannot be
// stalled.

module priority_voice_allocator #(
    parameter int NUM_VOICES     = pva_pkg::NUM_VOICES_DEF,
    parameter int MAX_DIST       = pva_pkg::MAX_DIST_DEF,
    parameter int PRIORITY_STEPS = pva_pkg::PRIORITY_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic [7:0]         i_owner_id,
    input  logic [7:0]         i_new_owner_id,
    input  logic               i_owner_is_player,
    input  logic [7:0]         i_sound_id,
    input  logic [7:0]         i_base_priority,
    input  logic signed [4:0]  i_voice_limit,
    input  logic [6:0]         i_volume,
    input  logic signed [31:0] i_offset_x,
    input  logic signed [31:0] i_offset_y,
    input  logic [2:0]         i_voice_index,
    output logic               o_valid,
    output logic [1:0]         o_action,
    output logic [2:0]         o_voice,
    output logic [7:0]         o_voice_sound,
    output logic [11:0]        o_scaled_priority,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    localparam int VW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW   = $clog2(NUM_VOICES + 1);
    localparam int ADJ0 = MAX_DIST / PRIORITY_STEPS;
    localparam int ADJ  = (ADJ0 == 0) ? 1 : ADJ0;

    pva_pkg::t_state r_state, n_state;

    // latched request
    logic [2:0]  r_req;
    logic [7:0]  r_owner, r_new_owner, r_snd, r_base;
    logic        r_player;
    logic [4:0]  r_lim;
    logic [6:0]  r_vol;
    logic [31:0] r_x, r_y;
    logic [2:0]  r_vidx;
    logic [CW-1:0] r_ch;

    // configuration
    logic [3:0] r_cfg_ch;
    logic       r_cfg_en;

    // distance and priority
    logic [31:0] r_ax, r_ay;
    logic [16:0] r_rem;
    logic [4:0]  r_steps;
    logic [11:0] r_pri;

    // scan bookkeeping
    logic [VW-1:0] r_idx, r_rs, r_lp, r_first, r_hi, r_lo, r_tgt;
    logic [CW-1:0] r_found;
    logic [11:0]   r_run;
    logic          r_lp_ok, r_first_ok, r_hi_ok, r_lo_ok, r_rr;

    // pending result and output registers
    logic        r_pend_v;
    logic [1:0]  r_pend_act;
    logic [VW-1:0] r_pend_voice;
    logic [7:0]  r_pend_snd;
    logic [11:0] r_pend_pri;
    logic        r_out_v, r_out_last;
    logic [1:0]  r_out_act;
    logic [2:0]  r_out_voice;
    logic [7:0]  r_out_snd;
    logic [11:0] r_out_pri;

    // ring of voice cells
    pva_pkg::t_voice w_q [NUM_VOICES];
    pva_pkg::t_voice w_head, w_wb;
    logic w_shift;

    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
        pva_pkg::t_voice w_d;
        if (g == NUM_VOICES - 1) begin : g_tail
            assign w_d = w_wb;
        end else begin : g_mid
            assign w_d = w_q[g + 1];
        end
        pva_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .o_q     (w_q[g])
        );
    end

    assign w_head = w_q[0];

    logic          w_accept, w_act, w_end, w_stop_ok, w_lim_hit, w_reject;
    logic [CW-1:0] w_rsn_full;
    logic [VW-1:0] w_rsn;
    logic [32:0]   w_sum;
    logic [31:0]   w_mn;
    logic [16:0]   w_dist;
    logic [4:0]    w_factor;
    logic [12:0]   w_prod;
    logic          w_lim_match, w_lim_low, w_free_hit, w_rr_hit;
    logic          w_first_now_ok, w_hi_now_ok, w_lo_now_ok;
    logic [CW-1:0] w_found_now;
    logic [VW-1:0] w_first_now, w_hi_now, w_lo_now;

    assign w_accept = start && !busy;
    assign w_act    = CW'(r_idx) < r_ch;
    assign w_end    = r_idx == VW'(NUM_VOICES - 1);

    // limit scan, counting the voice at the head in this cycle
    assign w_lim_match = w_act && (w_head.sound == r_snd) && (w_head.owner != '0);
    assign w_lim_low   = w_lim_match && (r_run >= w_head.prio);
    assign w_found_now = r_found + CW'(w_lim_match);
    assign w_lim_hit   = 6'(w_found_now) >= {2'b00, r_lim[3:0]};

    // round-robin start for this search
    assign w_rsn_full = CW'(r_rs) + CW'(1);
    assign w_rsn = (w_rsn_full >= r_ch) ? '0 : r_rs + VW'(1);

    // free and replaceable voice search, counting the head in this cycle
    assign w_free_hit     = w_act && (w_head.owner == '0);
    assign w_rr_hit       = w_act && (r_pri >= w_head.prio);
    assign w_first_now_ok = r_first_ok || w_free_hit;
    assign w_first_now    = r_first_ok ? r_first : r_idx;
    assign w_hi_now_ok    = r_hi_ok || (w_rr_hit && r_idx >= w_rsn);
    assign w_hi_now       = r_hi_ok ? r_hi : r_idx;
    assign w_lo_now_ok    = r_lo_ok || (w_rr_hit && r_idx < w_rsn);
    assign w_lo_now       = r_lo_ok ? r_lo : r_idx;

    // octagonal distance
    assign w_mn   = (r_ax < r_ay) ? r_ax : r_ay;
    assign w_sum  = {1'b0, r_ax} + {1'b0, r_ay} - {2'b00, w_mn[31:1]};
    assign w_dist = w_sum[32:16];
    assign w_reject = (r_snd == '0) || !r_cfg_en || (r_vol == '0) || (r_owner == '0) ||
                      (r_rem >= 17'(MAX_DIST));
    assign w_factor = 5'(PRIORITY_STEPS) - r_steps;
    assign w_prod   = {5'd0, r_base} * {8'd0, w_factor};

    assign w_shift = (r_state == pva_pkg::ST_LIMIT) || (r_state == pva_pkg::ST_EVICT) ||
                     (r_state == pva_pkg::ST_OWNER) || (r_state == pva_pkg::ST_FREE) ||
                     (r_state == pva_pkg::ST_PLACE) || (r_state == pva_pkg::ST_OP);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pva_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == pva_pkg::REQ_START) n_state = pva_pkg::ST_ABS;
                    else if (i_req_type <= pva_pkg::REQ_FINISH) n_state = pva_pkg::ST_OP;
                    else n_state = pva_pkg::ST_FLUSH;
                end
            end
            pva_pkg::ST_ABS:   n_state = pva_pkg::ST_DIST;
            pva_pkg::ST_DIST:  n_state = pva_pkg::ST_CHECK;
            pva_pkg::ST_CHECK: n_state = w_reject ? pva_pkg::ST_FLUSH : pva_pkg::ST_DIV;
            pva_pkg::ST_DIV: begin
                if (!(r_rem >= 17'(ADJ) && r_steps < 5'(PRIORITY_STEPS)))
                    n_state = pva_pkg::ST_MUL;
            end
            pva_pkg::ST_MUL: begin
                if (!r_lim[4]) n_state = pva_pkg::ST_LIMIT;
                else n_state = r_player ? pva_pkg::ST_FREE : pva_pkg::ST_OWNER;
            end
            pva_pkg::ST_LIMIT: begin
                if (w_end) begin
                    if (w_lim_hit) begin
                        n_state = (r_lp_ok || w_lim_low) ? pva_pkg::ST_EVICT
                                                         : pva_pkg::ST_FLUSH;
                    end else begin
                        n_state = r_player ? pva_pkg::ST_FREE : pva_pkg::ST_OWNER;
                    end
                end
            end
            pva_pkg::ST_EVICT: begin
                if (w_end) n_state = r_player ? pva_pkg::ST_FREE : pva_pkg::ST_OWNER;
            end
            pva_pkg::ST_OWNER: begin
                if (w_end) begin
                    n_state = (r_first_ok || w_stop_ok) ? pva_pkg::ST_PLACE
                                                        : pva_pkg::ST_FREE;
                end
            end
            pva_pkg::ST_FREE: begin
                if (w_end) begin
                    n_state = (w_first_now_ok || w_hi_now_ok || w_lo_now_ok)
                              ? pva_pkg::ST_PLACE : pva_pkg::ST_FLUSH;
                end
            end
            pva_pkg::ST_PLACE: if (w_end) n_state = pva_pkg::ST_DONE;
            pva_pkg::ST_OP:    if (w_end) n_state = pva_pkg::ST_FLUSH;
            pva_pkg::ST_DONE:  n_state = pva_pkg::ST_FLUSH;
            pva_pkg::ST_FLUSH: n_state = pva_pkg::ST_IDLE;
            default:           n_state = pva_pkg::ST_IDLE;
        endcase
    end

    // head of the ring: write-back value and result push
    logic          w_push;
    logic [1:0]    w_push_act;
    logic [VW-1:0] w_push_voice;
    logic [7:0]    w_push_snd;
    logic [11:0]   w_push_pri;

    always_comb begin
        w_wb         = w_head;
        w_push       = 1'b0;
        w_push_act   = pva_pkg::ACT_STOP;
        w_push_voice = r_idx;
        w_push_snd   = w_head.sound;
        w_push_pri   = '0;
        w_stop_ok    = 1'b0;
        unique case (r_state)
            pva_pkg::ST_OP: begin
                case (r_req)
                    pva_pkg::REQ_STOP_OWN: w_stop_ok = w_act && (w_head.owner == r_owner);
                    pva_pkg::REQ_RELINK: begin
                        if (r_owner != '0 && w_act && w_head.owner == r_owner)
                            w_wb.owner = r_new_owner;
                    end
                    pva_pkg::REQ_STOP_ALL: begin
                        w_push = w_act && (w_head.playing || w_head.owner != '0);
                        w_wb   = '0;
                    end
                    pva_pkg::REQ_FINISH: begin
                        if (w_act && 6'(r_idx) == 6'(r_vidx) && w_head.playing) begin
                            w_push        = 1'b1;
                            w_wb.owner    = '0;
                            w_wb.sound    = '0;
                            w_wb.playing  = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            pva_pkg::ST_EVICT: w_stop_ok = (r_idx == r_lp);
            pva_pkg::ST_OWNER: w_stop_ok = w_act && (w_head.owner == r_owner);
            pva_pkg::ST_PLACE: begin
                if (r_idx == r_tgt) begin
                    w_push = r_rr && w_head.playing;
                    w_wb   = '{owner: r_owner, sound: r_snd, prio: r_pri, playing: 1'b1};
                end
            end
            pva_pkg::ST_DONE: begin
                w_push       = 1'b1;
                w_push_act   = pva_pkg::ACT_START;
                w_push_voice = r_tgt;
                w_push_snd   = r_snd;
                w_push_pri   = r_pri;
            end
            default: ;
        endcase
        // stop of one voice
        if (w_stop_ok) begin
            w_push       = w_head.playing;
            w_wb.owner   = '0;
            w_wb.playing = 1'b0;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pva_pkg::ST_IDLE;
            r_cfg_ch   <= 4'd8;
            r_cfg_en   <= 1'b1;
            r_idx      <= '0;
            r_rs       <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_found    <= '0;
            r_lp_ok    <= 1'b0;
            r_first_ok <= 1'b0;
            r_hi_ok    <= 1'b0;
            r_lo_ok    <= 1'b0;
            r_rr       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= 1'b0;

            // configuration writes
            if (i_cfg_valid) begin
                if (i_cfg_index == pva_pkg::CFG_CHANNELS) r_cfg_ch <= i_cfg_data;
                else if (i_cfg_index == pva_pkg::CFG_ENABLE) r_cfg_en <= i_cfg_data[0];
            end

            // request capture
            if (w_accept) begin
                r_req       <= i_req_type;
                r_owner     <= i_owner_id;
                r_new_owner <= i_new_owner_id;
                r_player    <= i_owner_is_player;
                r_snd       <= i_sound_id;
                r_base      <= i_base_priority;
                r_lim       <= i_voice_limit;
                r_vol       <= i_volume;
                r_x         <= i_offset_x;
                r_y         <= i_offset_y;
                r_vidx      <= i_voice_index;
                if (r_cfg_ch == '0) r_ch <= CW'(1);
                else if (32'(r_cfg_ch) > NUM_VOICES) r_ch <= CW'(NUM_VOICES);
                else r_ch <= CW'(r_cfg_ch);
                r_idx      <= '0;
                r_found    <= '0;
                r_lp_ok    <= 1'b0;
                r_first_ok <= 1'b0;
                r_hi_ok    <= 1'b0;
                r_lo_ok    <= 1'b0;
                r_rr       <= 1'b0;
            end

            // distance and scaling
            if (r_state == pva_pkg::ST_ABS) begin
                r_ax <= r_x[31] ? (32'd0 - r_x) : r_x;
                r_ay <= r_y[31] ? (32'd0 - r_y) : r_y;
            end
            if (r_state == pva_pkg::ST_DIST) begin
                r_rem   <= w_dist;
                r_steps <= '0;
            end
            if (r_state == pva_pkg::ST_DIV && r_rem >= 17'(ADJ) &&
                r_steps < 5'(PRIORITY_STEPS)) begin
                r_rem   <= r_rem - 17'(ADJ);
                r_steps <= r_steps + 5'd1;
            end
            if (r_state == pva_pkg::ST_MUL) begin
                r_pri <= w_prod[11:0];
                r_run <= w_prod[11:0];
            end

            // scan index
            if (w_shift) r_idx <= w_end ? '0 : r_idx + VW'(1);

            // per-sound limit scan
            if (r_state == pva_pkg::ST_LIMIT && w_lim_match) begin
                r_found <= r_found + CW'(1);
                if (w_lim_low) begin
                    r_lp    <= r_idx;
                    r_lp_ok <= 1'b1;
                    r_run   <= w_head.prio;
                end
            end

            // owner scan: first match becomes the target
            if (r_state == pva_pkg::ST_OWNER && w_stop_ok && !r_first_ok) begin
                r_first    <= r_idx;
                r_first_ok <= 1'b1;
            end
            if (r_state == pva_pkg::ST_OWNER && w_end) begin
                r_tgt <= w_first_now;
                r_rr  <= 1'b0;
            end

            // free voice and round-robin scan
            if (r_state == pva_pkg::ST_FREE) begin
                if (w_free_hit && !r_first_ok) begin
                    r_first    <= r_idx;
                    r_first_ok <= 1'b1;
                end
                if (w_rr_hit) begin
                    if (r_idx >= w_rsn && !r_hi_ok) begin
                        r_hi    <= r_idx;
                        r_hi_ok <= 1'b1;
                    end
                    if (r_idx < w_rsn && !r_lo_ok) begin
                        r_lo    <= r_idx;
                        r_lo_ok <= 1'b1;
                    end
                end
                if (w_end) begin
                    if (w_first_now_ok) begin
                        r_tgt <= w_first_now;
                        r_rr  <= 1'b0;
                    end else begin
                        r_rs  <= w_rsn;
                        r_tgt <= w_hi_now_ok ? w_hi_now : w_lo_now;
                        r_rr  <= 1'b1;
                    end
                end
            end

            // result queue: hold one, release it when the next arrives or at the flush
            if (w_push) begin
                r_pend_v     <= 1'b1;
                r_pend_act   <= w_push_act;
                r_pend_voice <= w_push_voice;
                r_pend_snd   <= w_push_snd;
                r_pend_pri   <= w_push_pri;
                if (r_pend_v) begin
                    r_out_v     <= 1'b1;
                    r_out_last  <= 1'b0;
                    r_out_act   <= r_pend_act;
                    r_out_voice <= 3'(r_pend_voice);
                    r_out_snd   <= r_pend_snd;
                    r_out_pri   <= r_pend_pri;
                end
            end
            if (r_state == pva_pkg::ST_FLUSH) begin
                r_pend_v    <= 1'b0;
                r_out_v     <= 1'b1;
                r_out_last  <= 1'b1;
                r_out_act   <= r_pend_v ? r_pend_act : pva_pkg::ACT_NONE;
                r_out_voice <= r_pend_v ? 3'(r_pend_voice) : 3'd0;
                r_out_snd   <= r_pend_v ? r_pend_snd : 8'd0;
                r_out_pri   <= r_pend_v ? r_pend_pri : 12'd0;
            end
        end
    end

    // outputs
    always_comb begin
        busy              = r_state != pva_pkg::ST_IDLE;
        o_cfg_ready       = 1'b1;
        o_valid           = r_out_v;
        o_action          = r_out_act;
        o_voice           = r_out_voice;
        o_voice_sound     = r_out_snd;
        o_scaled_priority = r_out_pri;
        o_last            = r_out_last;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [2:0]         kind;
        logic [7:0]         owner;
        logic [7:0]         new_owner;
        logic               player;
        logic [7:0]         sound;
        logic [7:0]         base;
        logic signed [4:0]  limit;
        logic [6:0]         volume;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [2:0]         index;
        logic               has_act;
        logic [1:0]         want_act;
    } t_request;

    typedef struct {
        logic [1:0]  act;
        logic [2:0]  voice;
        logic [7:0]  sound;
        logic [11:0] prio;
        logic        last;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_req_type;
    logic [7:0]         i_owner_id;
    logic [7:0]         i_new_owner_id;
    logic               i_owner_is_player;
    logic [7:0]         i_sound_id;
    logic [7:0]         i_base_priority;
    logic signed [4:0]  i_voice_limit;
    logic [6:0]         i_volume;
    logic signed [31:0] i_offset_x;
    logic signed [31:0] i_offset_y;
    logic [2:0]         i_voice_index;
    logic               o_valid;
    logic [1:0]         o_action;
    logic [2:0]         o_voice;
    logic [7:0]         o_voice_sound;
    logic [11:0]        o_scaled_priority;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [3:0]         i_cfg_data;

    priority_voice_allocator u_top (.*);

    // shadow voice state and registers
    logic [7:0]  sh_owner [pva_pkg::NUM_VOICES_DEF];
    logic [7:0]  sh_sound [pva_pkg::NUM_VOICES_DEF];
    logic [11:0] sh_prio [pva_pkg::NUM_VOICES_DEF];
    logic        sh_playing [pva_pkg::NUM_VOICES_DEF];
    int unsigned sh_rotate;
    logic [3:0]  sh_channels;
    logic        sh_enable;

    t_outcome    pending_results[$];
    int          errors;
    logic        allow_gaps;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #600000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic int unsigned voice_count();
        int unsigned c;
        c = sh_channels;
        if (c == 0) c = 1;
        if (c > pva_pkg::NUM_VOICES_DEF) c = pva_pkg::NUM_VOICES_DEF;
        return c;
    endfunction

    task automatic push_result(logic [1:0] act, int unsigned v, logic [7:0] snd,
                               logic [11:0] pri);
        t_outcome r;
        r.act = act;
        r.voice = v[2:0];
        r.sound = snd;
        r.prio = pri;
        r.last = 1'b0;
        pending_results.push_back(r);
    endtask

    task automatic silence_voice(int unsigned v);
        if (sh_playing[v]) push_result(pva_pkg::ACT_STOP, v, sh_sound[v], '0);
        sh_playing[v] = 1'b0;
        sh_owner[v] = '0;
    endtask

    task automatic silence_owner(logic [7:0] owner, int unsigned ch);
        for (int unsigned v = 0; v < ch; v++)
            if (sh_owner[v] == owner) silence_voice(v);
    endtask

    // distance check, scaling, limit eviction and voice placement
    task automatic place_sound(t_request r, int unsigned ch);
        logic [32:0] ax, ay, mn;
        logic [33:0] span;
        int unsigned steps, factor, pri, found, run, v, k, adj;
        int          lp;
        logic        placed;
        ax = r.dx[31] ? 33'h1_0000_0000 - {1'b0, r.dx} : {1'b0, r.dx};
        ay = r.dy[31] ? 33'h1_0000_0000 - {1'b0, r.dy} : {1'b0, r.dy};
        mn = (ax < ay) ? ax : ay;
        span = ({1'b0, ax} + {1'b0, ay} - {1'b0, mn >> 1}) >> 16;
        if (r.sound == 0 || !sh_enable || r.volume == 0 || r.owner == 0) return;
        if (span >= pva_pkg::MAX_DIST_DEF) return;
        adj = pva_pkg::MAX_DIST_DEF / pva_pkg::PRIORITY_STEPS_DEF;
        if (adj == 0) adj = 1;
        steps = int'(span) / adj;
        factor = (steps >= pva_pkg::PRIORITY_STEPS_DEF) ? 0
                                                        : pva_pkg::PRIORITY_STEPS_DEF - steps;
        pri = r.base * factor;
        // per-sound limit
        if (!r.limit[4]) begin
            found = 0;
            run = pri;
            lp = -1;
            for (v = 0; v < ch; v++) begin
                if (sh_sound[v] == r.sound && sh_owner[v] != 0) begin
                    found++;
                    if (run >= sh_prio[v]) begin
                        lp = v;
                        run = sh_prio[v];
                    end
                end
            end
            if (found >= r.limit[3:0]) begin
                if (lp < 0) return;
                silence_voice(lp);
            end
        end
        // non-player owner keeps a single voice
        placed = 1'b0;
        v = 0;
        if (!r.player) begin
            for (k = 0; k < ch; k++) begin
                if (sh_owner[k] == r.owner) begin
                    silence_owner(r.owner, ch);
                    v = k;
                    placed = 1'b1;
                    break;
                end
            end
        end
        if (!placed) begin
            for (v = 0; v < ch; v++)
                if (sh_owner[v] == 0) break;
            if (v >= ch) begin
                sh_rotate++;
                if (sh_rotate >= ch) sh_rotate = 0;
                for (k = 0; k < ch; k++) begin
                    v = (sh_rotate + k) % ch;
                    if (pri >= sh_prio[v]) break;
                end
                if (k >= ch) return;
                silence_voice(v);
            end
        end
        sh_owner[v] = r.owner;
        sh_sound[v] = r.sound;
        sh_prio[v] = pri[11:0];
        sh_playing[v] = 1'b1;
        push_result(pva_pkg::ACT_START, v, r.sound, pri[11:0]);
    endtask

    task automatic predict_request(t_request r);
        int unsigned ch;
        int          first_pos;
        ch = voice_count();
        first_pos = pending_results.size();
        case (r.kind)
            pva_pkg::REQ_START: place_sound(r, ch);
            pva_pkg::REQ_STOP_OWN: silence_owner(r.owner, ch);
            pva_pkg::REQ_RELINK: begin
                if (r.owner != 0)
                    for (int unsigned v = 0; v < ch; v++)
                        if (sh_owner[v] == r.owner) sh_owner[v] = r.new_owner;
            end
            pva_pkg::REQ_STOP_ALL: begin
                for (int unsigned v = 0; v < pva_pkg::NUM_VOICES_DEF; v++) begin
                    if (v < ch && (sh_playing[v] || sh_owner[v] != 0))
                        push_result(pva_pkg::ACT_STOP, v, sh_sound[v], '0);
                    sh_owner[v] = '0;
                    sh_sound[v] = '0;
                    sh_prio[v] = '0;
                    sh_playing[v] = 1'b0;
                end
            end
            pva_pkg::REQ_FINISH: begin
                if (r.index < ch && sh_playing[r.index]) begin
                    push_result(pva_pkg::ACT_STOP, r.index, sh_sound[r.index], '0);
                    sh_playing[r.index] = 1'b0;
                    sh_owner[r.index] = '0;
                    sh_sound[r.index] = '0;
                end
            end
            default: ;
        endcase
        if (pending_results.size() == first_pos)
            push_result(pva_pkg::ACT_NONE, 0, '0, '0);
        pending_results[pending_results.size() - 1].last = 1'b1;
        // typed expectation of a directed row
        if (r.has_act && pending_results[first_pos].act != r.want_act) begin
            $display("%0t: directed action expected %0d, predicted %0d",
                     $time, r.want_act, pending_results[first_pos].act);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result act %0d voice %0d snd %0d pri %0d last %0d",
                         $time, o_action, o_voice, o_voice_sound, o_scaled_priority, o_last);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (e.act !== o_action || e.voice !== o_voice || e.sound !== o_voice_sound
                        || e.prio !== o_scaled_priority || e.last !== o_last) begin
                    $display("%0t: expected act %0d voice %0d snd %0d pri %0d last %0d",
                             $time, e.act, e.voice, e.sound, e.prio, e.last);
                    $display("%0t:   actual act %0d voice %0d snd %0d pri %0d last %0d",
                             $time, o_action, o_voice, o_voice_sound, o_scaled_priority,
                             o_last);
                    errors++;
                end
            end
        end
    end

    // issue one request, possibly after an idle burst
    task automatic send_request(t_request r);
        @(negedge i_clk);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= r.kind;
        i_owner_id <= r.owner;
        i_new_owner_id <= r.new_owner;
        i_owner_is_player <= r.player;
        i_sound_id <= r.sound;
        i_base_priority <= r.base;
        i_voice_limit <= r.limit;
        i_volume <= r.volume;
        i_offset_x <= r.dx;
        i_offset_y <= r.dy;
        i_voice_index <= r.index;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_request(r);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [3:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == pva_pkg::CFG_CHANNELS) sh_channels = data;
        else if (idx == pva_pkg::CFG_ENABLE) sh_enable = data[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_request make_row(logic [2:0] kind, logic [7:0] owner,
            logic [7:0] new_owner, logic player, logic [7:0] sound, logic [7:0] base,
            logic signed [4:0] limit, logic [6:0] volume, logic signed [31:0] dx,
            logic signed [31:0] dy, logic [2:0] index, logic has_act,
            logic [1:0] want_act);
        t_request r;
        r.kind = kind;
        r.owner = owner;
        r.new_owner = new_owner;
        r.player = player;
        r.sound = sound;
        r.base = base;
        r.limit = limit;
        r.volume = volume;
        r.dx = dx;
        r.dy = dy;
        r.index = index;
        r.has_act = has_act;
        r.want_act = want_act;
        return r;
    endfunction

    // mostly starts from a small pool of owners and sounds so voices collide
    function automatic t_request random_request();
        t_request r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) r.kind = pva_pkg::REQ_START;
        else if (pick < 70) r.kind = pva_pkg::REQ_STOP_OWN;
        else if (pick < 78) r.kind = pva_pkg::REQ_RELINK;
        else if (pick < 81) r.kind = pva_pkg::REQ_STOP_ALL;
        else if (pick < 97) r.kind = pva_pkg::REQ_FINISH;
        else r.kind = 3'($urandom_range(5, 7));
        r.owner = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
        r.new_owner = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        r.player = 1'($urandom);
        r.sound = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 5));
        r.base = 8'($urandom);
        r.limit = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4) - 1);
        r.volume = ($urandom_range(0, 15) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        if ($urandom_range(0, 7) == 0) begin
            r.dx = $urandom;
            r.dy = $urandom;
        end else begin
            r.dx = $signed($urandom_range(0, 2200 << 17)) - (2200 << 16);
            r.dy = $signed($urandom_range(0, 2200 << 17)) - (2200 << 16);
        end
        r.index = 3'($urandom);
        r.has_act = 1'b0;
        r.want_act = pva_pkg::ACT_NONE;
        return r;
    endfunction

    t_request directed_rows[$];

    initial begin
        logic [3:0] channel_plan [8];
        logic       enable_plan [8];
        start = 1'b0;
        i_rst_n = 1'b0;
        i_req_type = pva_pkg::REQ_STOP_ALL;
        i_owner_id = '0;
        i_new_owner_id = '0;
        i_owner_is_player = 1'b0;
        i_sound_id = '0;
        i_base_priority = '0;
        i_voice_limit = '0;
        i_volume = '0;
        i_offset_x = '0;
        i_offset_y = '0;
        i_voice_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pva_pkg::CFG_CHANNELS;
        i_cfg_data = '0;
        errors = 0;
        allow_gaps = 1'b1;
        for (int v = 0; v < pva_pkg::NUM_VOICES_DEF; v++) begin
            sh_owner[v] = '0;
            sh_sound[v] = '0;
            sh_prio[v] = '0;
            sh_playing[v] = 1'b0;
        end
        sh_rotate = 0;
        sh_channels = 4'd8;
        sh_enable = 1'b1;

        // rejects, extremes and every request kind
        directed_rows = '{
            make_row(pva_pkg::REQ_STOP_ALL, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 1, 0, 0, 0, 9, -1, 9, 0, 0, 0, 1,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 1, 0, 0, 3, 9, -1, 0, 0, 0, 0, 1,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 0, 0, 0, 3, 9, -1, 9, 0, 0, 0, 1,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 1, 0, 0, 3, 9, 0, 9, 0, 0, 0, 1,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 1, 0, 0, 3, 9, -1, 9, 32'h7fff_ffff, 0, 0, 1,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 1, 0, 0, 3, 9, -1, 9, 32'h8000_0000,
                     32'h8000_0000, 0, 1, pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 255, 0, 1, 255, 255, 15, 127, 0, 0, 0, 1,
                     pva_pkg::ACT_START),
            make_row(pva_pkg::REQ_START, 2, 0, 1, 7, 100, -1, 1, 2024 << 16, 0, 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 2, 0, 1, 7, 50, -1, 5, -(500 << 16), 700 << 16,
                     0, 0, pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 3, 0, 0, 7, 80, 2, 5, 10 << 16, 0, 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 4, 0, 0, 7, 200, 2, 5, 0, -(30 << 16), 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_START, 3, 0, 0, 9, 60, -1, 5, 0, 0, 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_RELINK, 0, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_RELINK, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_STOP_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_STOP_OWN, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_FINISH, 1, 0, 0, 0, 0, 0, 0, 0, 0, 7, 1,
                     pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_FINISH, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                     pva_pkg::ACT_STOP),
            make_row(3'd5, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, pva_pkg::ACT_NONE),
            make_row(3'd6, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, pva_pkg::ACT_NONE),
            make_row(3'd7, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, pva_pkg::ACT_NONE),
            make_row(pva_pkg::REQ_STOP_ALL, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     pva_pkg::ACT_NONE)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_request(directed_rows[i]);

        // random phases, each after writing the register settings from the plans
        channel_plan = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8, 4'd8};
        enable_plan = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        channel_plan[6] = 4'($urandom_range(2, 7));
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            write_register(pva_pkg::CFG_CHANNELS, channel_plan[ph]);
            write_register(pva_pkg::CFG_ENABLE, {3'd0, enable_plan[ph]});
            allow_gaps = (ph < 7);
            repeat (40) send_request(random_request());
        end

        drain_results();
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
